FILE: hw/rtl/lsoc_pkg.sv
// ----------------------------------------------------------------------------
// lsoc_pkg: shared types and codes of the lidar slope obstacle classifier
// Payload structs, class codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsoc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ROBOT_HEIGHT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_OBJECT_DIST = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROBOT_REACH     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_CHECK_DIST  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SLOPE_LIMIT     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DRIVABLE_STEP   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MAX_STEP        = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FOOTPRINT_VALID = 3'd7;

  // point classes
  localparam logic [2:0] CLASS_SKIPPED   = 3'd0;
  localparam logic [2:0] CLASS_GROUND    = 3'd1;
  localparam logic [2:0] CLASS_OBSTACLE  = 3'd2;
  localparam logic [2:0] CLASS_DRIVABLE  = 3'd3;
  localparam logic [2:0] CLASS_UNCERTAIN = 3'd4;
  localparam logic [2:0] CLASS_REFERENCE = 3'd5;

  typedef struct packed {
    logic signed [15:0] height_mm;
    logic [15:0]        range_mm;
    logic               in_footprint;
    logic               sweep_start;
  } in_t;

  typedef struct packed {
    logic [2:0] point_class;
    logic       is_obstacle;
  } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lidar_slope_obstacle_classifier.sv
// ----------------------------------------------------------------------------
// lidar_slope_obstacle_classifier
// Slope-based ground segmentation of range-sorted lidar points, one per beat.
// ----------------------------------------------------------------------------
// An accepted beat passes the input register, then the result register.
// Throughput: one point per cycle unless out_ready stalls; the input register
// feeds one 16x16 multiply and compare into the result register; the ground
// reference updates at the same edge, so the next point sees it at once.
// Reset: clears both stage valids, sets the ground reference to height 0 at
// range 0 and loads all configuration registers with their default values.
`default_nettype none

module lidar_slope_obstacle_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire lsoc_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output lsoc_pkg::out_t                          out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lsoc_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [lsoc_pkg::CfgDataW-1:0]      cfg_data
);

  // configuration
  logic signed [15:0] robot_height_r;
  logic [15:0]        min_object_distance_r;
  logic [15:0]        robot_reach_r;
  logic [15:0]        max_check_distance_r;
  logic [15:0]        slope_limit_r;
  logic [15:0]        drivable_step_r;
  logic [15:0]        max_step_r;
  logic               footprint_valid_r;

  // ground reference
  logic signed [15:0] ground_height_r;
  logic [15:0]        ground_range_r;

  // pipeline
  logic               s1_valid_r;
  lsoc_pkg::in_t      s1_r;
  logic               out_valid_r;
  lsoc_pkg::out_t     out_r;

  logic               s1_adv;
  logic               in_acc;

  logic signed [16:0] dz;
  logic signed [16:0] dd;
  logic [15:0]        adz;
  logic [15:0]        add;
  logic [31:0]        run_prod;
  logic [31:0]        rise_sc;
  logic               skip;
  logic               steep;
  logic [2:0]         cls_nxt;
  lsoc_pkg::out_t     out_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_height_r        <= 16'sd1000;
      min_object_distance_r <= 16'd0;
      robot_reach_r         <= 16'd1000;
      max_check_distance_r  <= 16'd2000;
      slope_limit_r         <= 16'd768;
      drivable_step_r       <= 16'd100;
      max_step_r            <= 16'd1000;
      footprint_valid_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsoc_pkg::REG_ROBOT_HEIGHT:    robot_height_r        <= $signed(cfg_data);
        lsoc_pkg::REG_MIN_OBJECT_DIST: min_object_distance_r <= cfg_data;
        lsoc_pkg::REG_ROBOT_REACH:     robot_reach_r         <= cfg_data;
        lsoc_pkg::REG_MAX_CHECK_DIST:  max_check_distance_r  <= cfg_data;
        lsoc_pkg::REG_SLOPE_LIMIT:     slope_limit_r         <= cfg_data;
        lsoc_pkg::REG_DRIVABLE_STEP:   drivable_step_r       <= cfg_data;
        lsoc_pkg::REG_MAX_STEP:        max_step_r            <= cfg_data;
        lsoc_pkg::REG_FOOTPRINT_VALID: footprint_valid_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance the input stage when the result register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
  end

  // classify against the current reference
  always_comb begin
    dz  = 17'(s1_r.height_mm) - 17'(ground_height_r);
    dd  = $signed({1'b0, s1_r.range_mm}) - $signed({1'b0, ground_range_r});
    adz = dz[16] ? 16'(-dz) : dz[15:0];
    add = dd[16] ? 16'(-dd) : dd[15:0];
    run_prod = slope_limit_r * add;
    rise_sc  = {8'd0, adz, 8'd0};
    steep    = rise_sc > run_prod;

    skip = (s1_r.height_mm >= robot_height_r) ||
           (s1_r.range_mm <= min_object_distance_r) ||
           (footprint_valid_r && (s1_r.range_mm < robot_reach_r) && s1_r.in_footprint) ||
           (dd >= $signed({1'b0, max_check_distance_r}));

    if (s1_r.sweep_start) begin
      cls_nxt = lsoc_pkg::CLASS_REFERENCE;
    end else if (skip) begin
      cls_nxt = lsoc_pkg::CLASS_SKIPPED;
    end else if (steep) begin
      cls_nxt = (adz > drivable_step_r) ? lsoc_pkg::CLASS_OBSTACLE
                                        : lsoc_pkg::CLASS_DRIVABLE;
    end else if (adz > max_step_r) begin
      cls_nxt = lsoc_pkg::CLASS_UNCERTAIN;
    end else begin
      cls_nxt = lsoc_pkg::CLASS_GROUND;
    end

    out_nxt.point_class = cls_nxt;
    out_nxt.is_obstacle = (cls_nxt == lsoc_pkg::CLASS_OBSTACLE);
  end

  // move the reference on a ground or reference point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_height_r <= 16'sd0;
      ground_range_r  <= 16'd0;
    end else if (s1_adv && ((cls_nxt == lsoc_pkg::CLASS_GROUND) ||
                            (cls_nxt == lsoc_pkg::CLASS_REFERENCE))) begin
      ground_height_r <= s1_r.height_mm;
      ground_range_r  <= s1_r.range_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_obst_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.is_obstacle == (out_r.point_class == lsoc_pkg::CLASS_OBSTACLE)))
    else $error("is_obstacle disagrees with point_class");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.point_class <= lsoc_pkg::CLASS_REFERENCE))
    else $error("point_class out of range");

  a_ref_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.sweep_start) |=>
      (ground_height_r == $past(s1_r.height_mm)) && (ground_range_r == $past(s1_r.range_mm)))
    else $error("reference point not loaded");

  a_ref_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(ground_range_r) |-> $past(s1_adv))
    else $error("ground reference moved without an advancing point");

endmodule

`default_nettype wire
